// ===== hw/rtl/rrr_pkg.sv =====
// Shared types and constants for the round-robin ready ring.
// No dependencies; every other file of the block imports this package.
package rrr_pkg;

    // Ring sizing
    localparam int MAX_TASKS    = 16;
    localparam int TASK_ID_BITS = 8;
    localparam int SLOT_W       = $clog2(MAX_TASKS);
    localparam int COUNT_W      = $clog2(MAX_TASKS + 1);

    // Port field widths
    localparam int OPCODE_W    = 2;
    localparam int STATUS_W    = 2;
    localparam int TASK_W      = 8;
    localparam int COUNT_OUT_W = 5;

    // Stored id bits: the id port carries TASK_W bits, masked to TASK_ID_BITS
    localparam int ID_W = (TASK_ID_BITS < TASK_W) ? TASK_ID_BITS : TASK_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_PEEK    = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_REMOVE_EMPTY = 2'd1,
        ST_FULL_DROP    = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [TASK_W-1:0]   task_id;
    } item_t;

    typedef struct packed {
        status_t             status;
        logic [TASK_W-1:0]   current_task;
        logic                queue_empty;
        logic [COUNT_W-1:0]  task_count;
    } result_t;

endpackage

// ===== hw/rtl/round_robin_ready_ring_core.sv =====
// Top level of the round-robin ready ring: input register, ring update, result register.
// Depends on rrr_pkg, rrr_in_reg, rrr_ring, rrr_out_reg.
//
//  channel   handshake              fields
//  -------   --------------------   ----------------------------------------------
//  request   req_valid / req_ready  opcode[1:0], task_id[7:0]
//  response  rsp_valid / rsp_ready  status[1:0], current_task[7:0], queue_empty,
//                                   task_count[4:0]
//
// Each item is held in the input register, where the ring update is done, and
// is loaded into the result register once that register is free; its response
// is then taken from the result register.
// A new item is taken every cycle while the response side keeps up.
// rsp_ready low holds the result register and then the input register.
// rst_n clears the slot-use map, pointers and count; no clearing pass.
module round_robin_ready_ring_core
    import rrr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  logic [OPCODE_W-1:0]    opcode,
    input  logic [TASK_W-1:0]      task_id,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output logic [STATUS_W-1:0]    status,
    output logic [TASK_W-1:0]      current_task,
    output logic                   queue_empty,
    output logic [COUNT_OUT_W-1:0] task_count
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    can_load;
    logic    fire;
    result_t result;
    result_t result_out;

    assign in_item.opcode  = opcode_t'(opcode);
    assign in_item.task_id = task_id;

    // update happens when a held item meets a free result register
    assign fire = item_valid && can_load;

    rrr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req_valid),
        .in_item    (in_item),
        .take       (fire),
        .ready      (req_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    rrr_ring u_ring (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .fire   (fire),
        .result (result)
    );

    rrr_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .result_in  (result),
        .out_ready  (rsp_ready),
        .can_load   (can_load),
        .out_valid  (rsp_valid),
        .result_out (result_out)
    );

    // response fields
    assign status       = result_out.status;
    assign current_task = result_out.current_task;
    assign queue_empty  = result_out.queue_empty;
    assign task_count   = COUNT_OUT_W'(result_out.task_count);

endmodule

// ===== hw/rtl/rrr_in_reg.sv =====
// Input register of the ready ring: holds one accepted item for the update.
// Depends on rrr_pkg.
module rrr_in_reg
    import rrr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  item_t in_item,
    input  logic  take,
    output logic  ready,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    item_t item_reg;

    // free, or emptied by the update in this same cycle
    assign ready      = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== hw/rtl/rrr_ring.sv =====
// Ring state (slot table, links, pointers, count) and its combinational next-state update.
// Depends on rrr_pkg; the result is combinational from the held item and state.
module rrr_ring
    import rrr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  logic    fire,
    output result_t result
);

    // slot table and links: contents undefined until written
    logic [ID_W-1:0]    slot_task_reg [MAX_TASKS];
    logic [SLOT_W-1:0]  next_link_reg [MAX_TASKS];
    logic [SLOT_W-1:0]  prev_link_reg [MAX_TASKS];
    logic [ID_W-1:0]    slot_task_next [MAX_TASKS];
    logic [SLOT_W-1:0]  next_link_next [MAX_TASKS];
    logic [SLOT_W-1:0]  prev_link_next [MAX_TASKS];

    // control state
    logic [MAX_TASKS-1:0] in_use_reg, in_use_next;
    logic [SLOT_W-1:0]    head_reg, head_next;
    logic [SLOT_W-1:0]    tail_reg, tail_next;
    logic [SLOT_W-1:0]    cur_reg, cur_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    logic [SLOT_W-1:0]    free_slot;
    logic                 free_found;
    logic [SLOT_W-1:0]    succ, pred;
    logic                 ring_empty, ring_single;
    status_t              status;
    logic [SLOT_W-1:0]    rd_slot;
    logic [ID_W-1:0]      rd_task;

    assign ring_empty  = (count_reg == '0);
    assign ring_single = (count_reg == COUNT_W'(1));
    assign succ        = next_link_reg[cur_reg];
    assign pred        = prev_link_reg[cur_reg];

    // lowest-numbered free slot
    always_comb
    begin
        free_slot  = '0;
        free_found = 1'b0;
        for (int i = MAX_TASKS - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_slot  = SLOT_W'(i);
                free_found = 1'b1;
            end
        end
    end

    // next state
    always_comb
    begin
        slot_task_next = slot_task_reg;
        next_link_next = next_link_reg;
        prev_link_next = prev_link_reg;
        in_use_next    = in_use_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cur_next       = cur_reg;
        count_next     = count_reg;
        status         = ST_OK;
        unique case (item.opcode)
            OP_ENQUEUE:
            begin
                if (!free_found)
                begin
                    status = ST_FULL_DROP;
                end
                else
                begin
                    in_use_next[free_slot]    = 1'b1;
                    slot_task_next[free_slot] = item.task_id[ID_W-1:0];
                    if (ring_empty)
                    begin
                        head_next                 = free_slot;
                        cur_next                  = free_slot;
                        next_link_next[free_slot] = free_slot;
                        prev_link_next[free_slot] = free_slot;
                    end
                    else
                    begin
                        next_link_next[tail_reg]  = free_slot;
                        prev_link_next[free_slot] = tail_reg;
                        next_link_next[free_slot] = head_reg;
                        prev_link_next[head_reg]  = free_slot;
                    end
                    tail_next  = free_slot;
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if (ring_empty)
                begin
                    status = ST_REMOVE_EMPTY;
                end
                else if (ring_single)
                begin
                    // last task leaves: ring and pointers return to reset
                    in_use_next = '0;
                    head_next   = '0;
                    tail_next   = '0;
                    cur_next    = '0;
                    count_next  = '0;
                end
                else
                begin
                    next_link_next[pred] = succ;
                    prev_link_next[succ] = pred;
                    if (cur_reg == head_reg)
                    begin
                        head_next = succ;
                    end
                    if (cur_reg == tail_reg)
                    begin
                        tail_next = pred;
                    end
                    in_use_next[cur_reg] = 1'b0;
                    cur_next             = succ;
                    count_next           = count_reg - COUNT_W'(1);
                end
            end
            OP_ADVANCE:
            begin
                if (!ring_empty)
                begin
                    cur_next = succ;
                end
            end
            OP_PEEK:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // task at the current slot after the step; a first enqueue bypasses the table
    always_comb
    begin
        if (item.opcode == OP_REMOVE || item.opcode == OP_ADVANCE)
        begin
            rd_slot = succ;
        end
        else
        begin
            rd_slot = cur_reg;
        end
        if (item.opcode == OP_ENQUEUE && ring_empty)
        begin
            rd_task = item.task_id[ID_W-1:0];
        end
        else
        begin
            rd_task = slot_task_reg[rd_slot];
        end
    end

    always_comb
    begin
        result.status       = status;
        result.queue_empty  = (count_next == '0);
        result.current_task = (count_next == '0) ? '0 : TASK_W'(rd_task);
        result.task_count   = count_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            cur_reg    <= '0;
            count_reg  <= '0;
        end
        else if (fire)
        begin
            in_use_reg <= in_use_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cur_reg    <= cur_next;
            count_reg  <= count_next;
        end
    end

    // table and links, no reset
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            slot_task_reg <= slot_task_next;
            next_link_reg <= next_link_next;
            prev_link_reg <= prev_link_next;
        end
    end

endmodule

// ===== hw/rtl/rrr_out_reg.sv =====
// Result register of the ready ring: holds one result item until taken.
// Depends on rrr_pkg.
module rrr_out_reg
    import rrr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result_in,
    input  logic    out_ready,
    output logic    can_load,
    output logic    out_valid,
    output result_t result_out
);

    logic    valid_reg;
    result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = result_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            result_reg <= result_in;
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for round_robin_ready_ring_core: directed and random scheduling items
// go through a local model of the slot ring, and each response is compared with it.
// Depends on rrr_pkg and the RTL of round_robin_ready_ring_core.
module testbench;
    import rrr_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD = 300;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_REPORTS = 10;
    localparam logic [TASK_W-1:0] ID_MASK = TASK_W'((1 << ID_W) - 1);

    // Operation mixes used by the random part
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_ready;
    logic [OPCODE_W-1:0]    opcode;
    logic [TASK_W-1:0]      task_id;
    logic                   rsp_valid;
    logic                   rsp_ready;
    logic [STATUS_W-1:0]    status;
    logic [TASK_W-1:0]      current_task;
    logic                   queue_empty;
    logic [COUNT_OUT_W-1:0] task_count;

    // Local copy of the ring
    logic [TASK_W-1:0]    slot_id [MAX_TASKS];
    logic [SLOT_W-1:0]    link_next [MAX_TASKS];
    logic [SLOT_W-1:0]    link_prev [MAX_TASKS];
    logic [MAX_TASKS-1:0] slot_busy;
    logic [SLOT_W-1:0]    head_idx;
    logic [SLOT_W-1:0]    tail_idx;
    logic [SLOT_W-1:0]    cur_idx;
    logic [COUNT_W-1:0]   ring_len;

    result_t pending_rsp[$];
    int      err_count = 0;
    int      cycle_count = 0;
    bit      gaps_on = 1'b1;
    bit      stalls_on = 1'b1;
    bit      hold_rsp = 1'b0;
    bit      req_up = 1'b0;

    round_robin_ready_ring_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .opcode       (opcode),
        .task_id      (task_id),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .status       (status),
        .current_task (current_task),
        .queue_empty  (queue_empty),
        .task_count   (task_count)
    );

    always #HALF_PERIOD clk = ~clk;

    // Empty ring, pointers back to slot 0
    function automatic void ring_clear();
        slot_busy = '0;
        head_idx = '0;
        tail_idx = '0;
        cur_idx = '0;
        ring_len = '0;
    endfunction

    // Apply one item to the local ring and return the response it must produce
    function automatic result_t ring_step(opcode_t op, logic [TASK_W-1:0] id);
        result_t           r;
        logic [SLOT_W-1:0] free_idx;
        logic [SLOT_W-1:0] p;
        logic [SLOT_W-1:0] n;
        bit                found;
        r.status = ST_OK;
        free_idx = '0;
        found = 1'b0;
        case (op)
            OP_ENQUEUE:
            begin
                // lowest free slot wins
                for (int i = MAX_TASKS - 1; i >= 0; i--)
                begin
                    if (!slot_busy[i])
                    begin
                        free_idx = SLOT_W'(i);
                        found = 1'b1;
                    end
                end
                if (!found || ring_len >= MAX_TASKS)
                begin
                    r.status = ST_FULL_DROP;
                end
                else
                begin
                    slot_busy[free_idx] = 1'b1;
                    slot_id[free_idx] = id & ID_MASK;
                    if (ring_len == 0)
                    begin
                        head_idx = free_idx;
                        tail_idx = free_idx;
                        cur_idx = free_idx;
                        link_next[free_idx] = free_idx;
                        link_prev[free_idx] = free_idx;
                    end
                    else
                    begin
                        link_next[tail_idx] = free_idx;
                        link_prev[free_idx] = tail_idx;
                        link_next[free_idx] = head_idx;
                        link_prev[head_idx] = free_idx;
                        tail_idx = free_idx;
                    end
                    ring_len = ring_len + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (ring_len == 0)
                begin
                    r.status = ST_REMOVE_EMPTY;
                end
                else if (ring_len == 1)
                begin
                    ring_clear();
                end
                else
                begin
                    // unlink current, successor takes over
                    p = link_prev[cur_idx];
                    n = link_next[cur_idx];
                    link_next[p] = n;
                    link_prev[n] = p;
                    if (cur_idx == head_idx)
                        head_idx = n;
                    if (cur_idx == tail_idx)
                        tail_idx = p;
                    slot_busy[cur_idx] = 1'b0;
                    cur_idx = n;
                    ring_len = ring_len - 1'b1;
                end
            end
            OP_ADVANCE:
            begin
                if (ring_len != 0)
                    cur_idx = link_next[cur_idx];
            end
            default:
            begin
            end
        endcase
        r.current_task = (ring_len != 0) ? slot_id[cur_idx] : '0;
        r.queue_empty = (ring_len == 0);
        r.task_count = ring_len;
        return r;
    endfunction

    function automatic opcode_t pick_op(mix_t mode);
        int roll;
        roll = $urandom_range(0, 99);
        case (mode)
            MIX_FILL:
                return (roll < 55) ? OP_ENQUEUE : (roll < 70) ? OP_REMOVE :
                       (roll < 90) ? OP_ADVANCE : OP_PEEK;
            MIX_DRAIN:
                return (roll < 15) ? OP_ENQUEUE : (roll < 65) ? OP_REMOVE :
                       (roll < 85) ? OP_ADVANCE : OP_PEEK;
            default:
                return (roll < 35) ? OP_ENQUEUE : (roll < 65) ? OP_REMOVE :
                       (roll < 85) ? OP_ADVANCE : OP_PEEK;
        endcase
    endfunction

    // Drop valid after the last accepted item, then wait on a clock edge before returning
    task automatic lower_req();
        if (req_up)
        begin
            req_valid <= 1'b0;
            req_up = 1'b0;
            @(posedge clk);
        end
    endtask

    // Offer one item, wait for acceptance, record what it must produce
    task automatic send_item(opcode_t op, logic [TASK_W-1:0] id);
        int gap;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 9);
            lower_req();
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        opcode <= op;
        task_id <= id;
        req_up = 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_rsp.push_back(ring_step(op, id));
    endtask

    // Sender pauses until every outstanding response is back
    task automatic wait_drained();
        lower_req();
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    // Peek, remove and advance on an empty ring
    task automatic test_empty_ring();
        send_item(OP_PEEK, 8'h00);
        send_item(OP_REMOVE, 8'hFF);
        send_item(OP_ADVANCE, 8'h00);
    endtask

    // Two tasks: advance onto the tail, remove the tail, then remove the last task
    task automatic test_link_edges();
        send_item(OP_ENQUEUE, 8'h00);
        send_item(OP_ENQUEUE, 8'hFF);
        send_item(OP_ADVANCE, 8'h00);
        send_item(OP_REMOVE, 8'h00);
        send_item(OP_REMOVE, 8'h00);
    endtask

    // Fill every slot, try one more, then remove the head and peek
    task automatic test_full_table();
        logic [TASK_W-1:0] fill_ids [MAX_TASKS] = '{
            8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0,
            8'h33, 8'hCC, 8'h7F, 8'hFE, 8'h02, 8'h40, 8'h10, 8'h08
        };
        for (int k = 0; k < MAX_TASKS; k++)
            send_item(OP_ENQUEUE, fill_ids[k]);
        send_item(OP_ENQUEUE, 8'h99);
        send_item(OP_REMOVE, 8'h00);
        send_item(OP_PEEK, 8'h00);
    endtask

    // Random items in chunks that lean toward filling, draining or neither
    task automatic test_random_mix(int items);
        mix_t mode;
        mode = MIX_EVEN;
        for (int n = 0; n < items; n++)
        begin
            if (n % 50 == 0)
            begin
                mode = mix_t'($urandom_range(0, 2));
                gaps_on = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 7) == 0)
                    wait_drained();
            end
            send_item(pick_op(mode), TASK_W'($urandom));
        end
    endtask

    // Response side held off for a long stretch while items keep coming
    task automatic test_backpressure();
        hold_rsp = 1'b1;
        for (int n = 0; n < 40; n++)
            send_item(pick_op(MIX_EVEN), TASK_W'($urandom));
        wait_drained();
    endtask

    // Sender waits for every response before going on
    task automatic test_drain_pause();
        for (int n = 0; n < 20; n++)
            send_item(pick_op(MIX_FILL), TASK_W'($urandom));
        wait_drained();
        for (int n = 0; n < 20; n++)
            send_item(pick_op(MIX_DRAIN), TASK_W'($urandom));
        wait_drained();
    endtask

    // Back-to-back items with no idling on either side
    task automatic test_steady_stream(int items);
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        for (int n = 0; n < items; n++)
            send_item(pick_op(MIX_EVEN), TASK_W'($urandom));
    endtask

    // Response side: ready with random stall bursts, plus the long hold on request
    initial
    begin : rsp_side
        int burst;
        rsp_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_rsp)
            begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 9);
                rsp_ready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare every accepted response with the oldest expectation
    always @(posedge clk)
    begin : rsp_check
        result_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected response: status %0d task %0d empty %0d count %0d",
                             status, current_task, queue_empty, task_count);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (status !== want.status || current_task !== want.current_task ||
                    queue_empty !== want.queue_empty || task_count !== want.task_count)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                    begin
                        $write("mismatch: expected status %0d task %0d empty %0d count %0d,",
                               want.status, want.current_task, want.queue_empty,
                               want.task_count);
                        $display(" got status %0d task %0d empty %0d count %0d",
                                 status, current_task, queue_empty, task_count);
                    end
                end
            end
        end
    end

    // Run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: errors");
        $finish;
    end

    // Test sequence
    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        opcode = OP_PEEK;
        task_id = '0;
        ring_clear();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_ring();
        test_link_edges();
        test_full_table();
        test_random_mix(850);
        test_backpressure();
        test_drain_pause();
        test_random_mix(850);
        test_steady_stream(200);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_rsp.size() != 0)
            err_count++;
        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
